// ----- rtl/core/sha1md_pkg.sv -----
// ----------------------------------------------------------------------------
// sha1md_pkg
// types and constants shared by the message digest front end, queue and engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package sha1md_pkg;

    localparam int COUNT_W = 61;

    localparam logic [31:0] H0_INIT = 32'h6745_2301;
    localparam logic [31:0] H1_INIT = 32'hEFCD_AB89;
    localparam logic [31:0] H2_INIT = 32'h98BA_DCFE;
    localparam logic [31:0] H3_INIT = 32'h1032_5476;
    localparam logic [31:0] H4_INIT = 32'hC3D2_E1F0;

    localparam logic [31:0] K_ROUND0 = 32'h5A82_7999;
    localparam logic [31:0] K_ROUND1 = 32'h6ED9_EBA1;
    localparam logic [31:0] K_ROUND2 = 32'h8F1B_BCDC;
    localparam logic [31:0] K_ROUND3 = 32'hCA62_C1D6;

    localparam logic [7:0] PAD_MARK = 8'h80;

    localparam logic [2:0] LAST_INDEX = 3'd4;

    typedef struct packed {
        logic [7:0] msg_byte;
        logic       has_byte;
        logic       end_of_message;
    } msg_item_t;

    typedef struct packed {
        logic [31:0] digest_word;
        logic [2:0]  word_index;
        logic        last_word;
    } digest_item_t;

    typedef enum logic [1:0] {
        CMD_BYTE,
        CMD_END,
        CMD_BYTE_END
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t  kind;
        logic [7:0] data;
    } cmd_t;

    typedef enum logic [2:0] {
        ST_INTAKE,
        ST_PAD,
        ST_LEN,
        ST_ROUND,
        ST_FOLD,
        ST_OUTPUT
    } state_t;

endpackage

// ----- rtl/core/sha1md_front.sv -----
// ----------------------------------------------------------------------------
// sha1md_front
// accepts message items, drops empty ones and classifies the rest into commands
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1md_front
(
    input  logic                  msg_valid,
    output logic                  msg_stall,
    input  sha1md_pkg::msg_item_t msg_item,
    input  logic                  q_full,
    output logic                  push,
    output sha1md_pkg::cmd_t      cmd
);

    logic useful;

    assign msg_stall = q_full;

    always_comb
    begin
        cmd.data = msg_item.msg_byte;
        useful   = 1'b1;
        unique case ({msg_item.has_byte, msg_item.end_of_message})
            2'b10:   cmd.kind = sha1md_pkg::CMD_BYTE;
            2'b01:   cmd.kind = sha1md_pkg::CMD_END;
            2'b11:   cmd.kind = sha1md_pkg::CMD_BYTE_END;
            default:
            begin
                // neither byte nor end: nothing to do
                cmd.kind = sha1md_pkg::CMD_BYTE;
                useful   = 1'b0;
            end
        endcase
    end

    assign push = msg_valid && !q_full && useful;

endmodule

// ----- rtl/core/sha1md_queue.sv -----
// ----------------------------------------------------------------------------
// sha1md_queue
// small command fifo between the front end and the compression engine
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1md_queue
#(
    parameter int DEPTH = 4
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    input  sha1md_pkg::cmd_t push_cmd,
    output logic             full,
    output logic             head_valid,
    output sha1md_pkg::cmd_t head_cmd,
    input  logic             pop
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    sha1md_pkg::cmd_t   mem [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg;
    logic [PTR_W-1:0]   wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg;
    logic [PTR_W-1:0]   rd_ptr_next;
    logic [CNT_W-1:0]   count_reg;
    logic [CNT_W-1:0]   count_next;
    logic               do_pop;

    assign full       = (count_reg == CNT_W'(DEPTH));
    assign head_valid = (count_reg != '0);
    assign head_cmd   = mem[rd_ptr_reg];
    assign do_pop     = pop && head_valid;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !do_pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (!push && do_pop)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// ----- rtl/core/sha1md_engine.sv -----
// ----------------------------------------------------------------------------
// sha1md_engine
// byte gathering, padding, 80-round compression and digest word output
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1md_engine
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     cmd_valid,
    input  sha1md_pkg::cmd_t         cmd,
    output logic                     cmd_pop,
    output logic                     digest_valid,
    input  logic                     digest_stall,
    output sha1md_pkg::digest_item_t digest_item
);

    localparam int CW = sha1md_pkg::COUNT_W;

    sha1md_pkg::state_t       state_reg;
    sha1md_pkg::state_t       state_next;
    sha1md_pkg::state_t       resume_reg;
    sha1md_pkg::state_t       resume_next;
    logic [31:0]              chain_reg [5];
    logic [31:0]              chain_next [5];
    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic [5:0]               pos_reg;
    logic [5:0]               pos_next;
    logic                     pad_first_reg;
    logic                     pad_first_next;
    logic [6:0]               round_reg;
    logic [6:0]               round_next;
    logic [2:0]               out_idx_reg;
    logic [2:0]               out_idx_next;
    logic                     out_valid_reg;
    logic                     out_valid_next;
    sha1md_pkg::digest_item_t out_item_reg;
    sha1md_pkg::digest_item_t out_item_next;
    logic [31:0]              win_reg [16];
    logic [31:0]              win_next [16];
    logic [31:0]              wv_reg [5];
    logic [31:0]              wv_next [5];
    logic [63:0]              len_reg;
    logic [63:0]              len_next;

    logic                     sh_en;
    logic [7:0]               sh_byte;
    logic [CW-1:0]            count_inc;
    logic [31:0]              f_val;
    logic [31:0]              k_val;
    logic [31:0]              t_val;
    logic [31:0]              w_mix;
    logic [31:0]              w_new;
    logic                     out_free;

    assign count_inc = count_reg + 1'b1;
    assign out_free  = !out_valid_reg || !digest_stall;

    // round function and constant by round group
    always_comb
    begin
        if (round_reg < 7'd20)
        begin
            f_val = (wv_reg[1] & wv_reg[2]) | (~wv_reg[1] & wv_reg[3]);
            k_val = sha1md_pkg::K_ROUND0;
        end
        else if (round_reg < 7'd40)
        begin
            f_val = wv_reg[1] ^ wv_reg[2] ^ wv_reg[3];
            k_val = sha1md_pkg::K_ROUND1;
        end
        else if (round_reg < 7'd60)
        begin
            f_val = (wv_reg[1] & wv_reg[2]) | (wv_reg[1] & wv_reg[3])
                  | (wv_reg[2] & wv_reg[3]);
            k_val = sha1md_pkg::K_ROUND2;
        end
        else
        begin
            f_val = wv_reg[1] ^ wv_reg[2] ^ wv_reg[3];
            k_val = sha1md_pkg::K_ROUND3;
        end
    end

    assign t_val = {wv_reg[0][26:0], wv_reg[0][31:27]} + f_val + wv_reg[4] + k_val + win_reg[0];
    assign w_mix = win_reg[13] ^ win_reg[8] ^ win_reg[2] ^ win_reg[0];
    assign w_new = {w_mix[30:0], w_mix[31]};

    always_comb
    begin
        state_next     = state_reg;
        resume_next    = resume_reg;
        chain_next     = chain_reg;
        count_next     = count_reg;
        pos_next       = pos_reg;
        pad_first_next = pad_first_reg;
        round_next     = round_reg;
        out_idx_next   = out_idx_reg;
        out_valid_next = out_valid_reg && digest_stall;
        out_item_next  = out_item_reg;
        win_next       = win_reg;
        wv_next        = wv_reg;
        len_next       = len_reg;
        sh_en          = 1'b0;
        sh_byte        = cmd.data;
        cmd_pop        = 1'b0;

        unique case (state_reg)
            sha1md_pkg::ST_INTAKE:
            begin
                if (cmd_valid)
                begin
                    cmd_pop = 1'b1;
                    unique case (cmd.kind)
                        sha1md_pkg::CMD_BYTE:
                        begin
                            sh_en      = 1'b1;
                            count_next = count_inc;
                            pos_next   = pos_reg + 1'b1;
                            if (pos_reg == 6'd63)
                            begin
                                state_next  = sha1md_pkg::ST_ROUND;
                                resume_next = sha1md_pkg::ST_INTAKE;
                                wv_next     = chain_reg;
                                round_next  = '0;
                            end
                        end
                        sha1md_pkg::CMD_BYTE_END:
                        begin
                            sh_en          = 1'b1;
                            count_next     = count_inc;
                            pos_next       = pos_reg + 1'b1;
                            len_next       = {count_inc, 3'b000};
                            pad_first_next = 1'b1;
                            if (pos_reg == 6'd63)
                            begin
                                state_next  = sha1md_pkg::ST_ROUND;
                                resume_next = sha1md_pkg::ST_PAD;
                                wv_next     = chain_reg;
                                round_next  = '0;
                            end
                            else
                            begin
                                state_next = sha1md_pkg::ST_PAD;
                            end
                        end
                        sha1md_pkg::CMD_END:
                        begin
                            len_next       = {count_reg, 3'b000};
                            pad_first_next = 1'b1;
                            state_next     = sha1md_pkg::ST_PAD;
                        end
                        default:
                        begin
                            cmd_pop = 1'b1;
                        end
                    endcase
                end
            end

            sha1md_pkg::ST_PAD:
            begin
                sh_en          = 1'b1;
                sh_byte        = pad_first_reg ? sha1md_pkg::PAD_MARK : 8'h00;
                pad_first_next = 1'b0;
                pos_next       = pos_reg + 1'b1;
                if (pos_reg == 6'd63)
                begin
                    // no room for the length: finish this block first
                    state_next  = sha1md_pkg::ST_ROUND;
                    resume_next = sha1md_pkg::ST_PAD;
                    wv_next     = chain_reg;
                    round_next  = '0;
                end
                else if (pos_reg == 6'd55)
                begin
                    state_next = sha1md_pkg::ST_LEN;
                end
            end

            sha1md_pkg::ST_LEN:
            begin
                sh_en    = 1'b1;
                sh_byte  = len_reg[63:56];
                len_next = {len_reg[55:0], 8'h00};
                pos_next = pos_reg + 1'b1;
                if (pos_reg == 6'd63)
                begin
                    state_next  = sha1md_pkg::ST_ROUND;
                    resume_next = sha1md_pkg::ST_OUTPUT;
                    wv_next     = chain_reg;
                    round_next  = '0;
                end
            end

            sha1md_pkg::ST_ROUND:
            begin
                wv_next[0] = t_val;
                wv_next[1] = wv_reg[0];
                wv_next[2] = {wv_reg[1][1:0], wv_reg[1][31:2]};
                wv_next[3] = wv_reg[2];
                wv_next[4] = wv_reg[3];
                for (int i = 0; i < 15; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[15] = w_new;
                round_next   = round_reg + 1'b1;
                if (round_reg == 7'd79)
                begin
                    state_next = sha1md_pkg::ST_FOLD;
                    round_next = '0;
                end
            end

            sha1md_pkg::ST_FOLD:
            begin
                for (int i = 0; i < 5; i++)
                begin
                    chain_next[i] = chain_reg[i] + wv_reg[i];
                end
                state_next   = resume_reg;
                out_idx_next = '0;
            end

            sha1md_pkg::ST_OUTPUT:
            begin
                if (out_free)
                begin
                    out_valid_next            = 1'b1;
                    out_item_next.digest_word = chain_reg[out_idx_reg];
                    out_item_next.word_index  = out_idx_reg;
                    out_item_next.last_word   = (out_idx_reg == sha1md_pkg::LAST_INDEX);
                    if (out_idx_reg == sha1md_pkg::LAST_INDEX)
                    begin
                        chain_next[0] = sha1md_pkg::H0_INIT;
                        chain_next[1] = sha1md_pkg::H1_INIT;
                        chain_next[2] = sha1md_pkg::H2_INIT;
                        chain_next[3] = sha1md_pkg::H3_INIT;
                        chain_next[4] = sha1md_pkg::H4_INIT;
                        count_next    = '0;
                        pos_next      = '0;
                        state_next    = sha1md_pkg::ST_INTAKE;
                    end
                    else
                    begin
                        out_idx_next = out_idx_reg + 1'b1;
                    end
                end
            end

            default:
            begin
                state_next = sha1md_pkg::ST_INTAKE;
            end
        endcase

        // byte-wide shift of the whole 64-byte window
        if (sh_en)
        begin
            for (int i = 0; i < 15; i++)
            begin
                win_next[i] = {win_reg[i][23:0], win_reg[i + 1][31:24]};
            end
            win_next[15] = {win_reg[15][23:0], sh_byte};
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= sha1md_pkg::ST_INTAKE;
            resume_reg    <= sha1md_pkg::ST_INTAKE;
            chain_reg[0]  <= sha1md_pkg::H0_INIT;
            chain_reg[1]  <= sha1md_pkg::H1_INIT;
            chain_reg[2]  <= sha1md_pkg::H2_INIT;
            chain_reg[3]  <= sha1md_pkg::H3_INIT;
            chain_reg[4]  <= sha1md_pkg::H4_INIT;
            count_reg     <= '0;
            pos_reg       <= '0;
            pad_first_reg <= 1'b0;
            round_reg     <= '0;
            out_idx_reg   <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            resume_reg    <= resume_next;
            chain_reg     <= chain_next;
            count_reg     <= count_next;
            pos_reg       <= pos_next;
            pad_first_reg <= pad_first_next;
            round_reg     <= round_next;
            out_idx_reg   <= out_idx_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_item_reg <= out_item_next;
        win_reg      <= win_next;
        wv_reg       <= wv_next;
        len_reg      <= len_next;
    end

    assign digest_valid = out_valid_reg;
    assign digest_item  = out_item_reg;

endmodule

// ----- rtl/core/sha1_message_digest.sv -----
// ----------------------------------------------------------------------------
// sha1_message_digest
// byte-serial sha-1 hash with padding and five-word digest output
// ----------------------------------------------------------------------------
// per block: 64 bytes are taken in one by one, then 80 rounds and a fold follow
//   on the single round unit; no new bytes are taken while it compresses
// after the end item reaches the engine, padding runs one byte per cycle
//   and one or two compressions follow before the first of 5 items
// reset: asynchronous; chain value back to the initial constants, counters
//   cleared, queue empty; buffer and schedule storage need no clearing pass
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module sha1_message_digest
#(
    parameter int QUEUE_DEPTH = 4
)
(
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     msg_valid,
    output logic                     msg_stall,
    input  sha1md_pkg::msg_item_t    msg_item,
    output logic                     digest_valid,
    input  logic                     digest_stall,
    output sha1md_pkg::digest_item_t digest_item
);

    // command path: front end -> queue -> engine
    logic             q_push;
    logic             q_full;
    logic             q_valid;
    logic             q_pop;
    sha1md_pkg::cmd_t front_cmd;
    sha1md_pkg::cmd_t head_cmd;

    // front end drops items with neither byte nor end marker
    sha1md_front u_front
    (
        .msg_valid (msg_valid),
        .msg_stall (msg_stall),
        .msg_item  (msg_item),
        .q_full    (q_full),
        .push      (q_push),
        .cmd       (front_cmd)
    );

    // queue lets the front keep accepting items while the engine compresses
    sha1md_queue
    #(
        .DEPTH (QUEUE_DEPTH)
    )
    u_queue
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (q_push),
        .push_cmd   (front_cmd),
        .full       (q_full),
        .head_valid (q_valid),
        .head_cmd   (head_cmd),
        .pop        (q_pop)
    );

    // engine gathers bytes into the window, pads, compresses and emits the digest
    sha1md_engine u_engine
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd_valid    (q_valid),
        .cmd          (head_cmd),
        .cmd_pop      (q_pop),
        .digest_valid (digest_valid),
        .digest_stall (digest_stall),
        .digest_item  (digest_item)
    );

    // never write into a full queue
    assert property (@(posedge clk) disable iff (!rst_n) q_push |-> !q_full)
        else $error("command pushed into full queue");

    // the flag of the final word matches its index
    assert property (@(posedge clk) disable iff (!rst_n)
        digest_valid |-> (digest_item.last_word ==
                          (digest_item.word_index == sha1md_pkg::LAST_INDEX)))
        else $error("last_word does not match word_index");

    // digest words come out in order: after a taken word the next shown is its successor
    assert property (@(posedge clk) disable iff (!rst_n)
        (digest_valid && !digest_stall && !digest_item.last_word) ##1 digest_valid
        |-> (digest_item.word_index == $past(digest_item.word_index) + 3'd1))
        else $error("digest word index out of sequence");

endmodule
